[rtl/shlsu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package shlsu_pkg;

  typedef enum logic [4:0] {
    FN_AND    = 5'd0,
    FN_NOT    = 5'd1,
    FN_OR     = 5'd2,
    FN_TST    = 5'd3,
    FN_XOR    = 5'd4,
    FN_ROTL   = 5'd5,
    FN_ROTR   = 5'd6,
    FN_ROTCL  = 5'd7,
    FN_ROTCR  = 5'd8,
    FN_SHAL   = 5'd9,
    FN_SHLL   = 5'd10,
    FN_SHAR   = 5'd11,
    FN_SHLR   = 5'd12,
    FN_SHLL2  = 5'd13,
    FN_SHLR2  = 5'd14,
    FN_SHLL8  = 5'd15,
    FN_SHLR8  = 5'd16,
    FN_SHLL16 = 5'd17,
    FN_SHLR16 = 5'd18,
    FN_SHAD   = 5'd19,
    FN_SHLD   = 5'd20,
    FN_SHLLV  = 5'd21,
    FN_SHLRV  = 5'd22,
    FN_SHARV  = 5'd23,
    FN_LDSH16 = 5'd24
  } func_e;

  typedef struct packed {
    logic [4:0]         func;
    logic               wide;
    logic               use_imm;
    logic               copy_imm;
    logic [3:0]         src_a_reg;
    logic [3:0]         src_b_reg;
    logic [3:0]         dest_reg;
    logic signed [31:0] imm_value;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        t_out;
    logic        wrote_reg;
  } out_t;

  // register file write word: immediate copy into the low bank plus result write
  typedef struct packed {
    logic        cp_en;
    logic        lo_en;
    logic        hi_en;
    logic [31:0] cp_data;
    logic [31:0] lo_data;
    logic [31:0] hi_data;
  } rf_wr_t;

endpackage

`default_nettype wire

[rtl/shlsu_regfile.sv]
`timescale 1ns / 1ps
`default_nettype none

module shlsu_regfile #(
  parameter int NUM_REGS = 16,
  localparam int IdxW = $clog2(NUM_REGS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [IdxW-1:0]   ra_i,
  input  wire logic [IdxW-1:0]   rb_i,
  input  wire shlsu_pkg::rf_wr_t wr_i,
  input  wire logic [IdxW-1:0]   cp_addr_i,
  input  wire logic [IdxW-1:0]   rd_addr_i,
  output logic [31:0]            a_lo_o,
  output logic [31:0]            a_hi_o,
  output logic [31:0]            b_lo_o,
  output logic [31:0]            b_hi_o
);
  import shlsu_pkg::*;

  // Low bank has two writers per word: one memory per writer, and a per-entry
  // select bit naming the one that holds the live value.
  logic [31:0] mem_cp  [NUM_REGS];
  logic [31:0] mem_res [NUM_REGS];
  logic [31:0] mem_hi  [NUM_REGS];

  logic [NUM_REGS-1:0] lo_vld_q, lo_vld_d;
  logic [NUM_REGS-1:0] lo_sel_q, lo_sel_d;
  logic [NUM_REGS-1:0] hi_vld_q, hi_vld_d;

  logic [31:0] cp_a_q, cp_b_q, res_a_q, res_b_q, hi_a_q, hi_b_q;
  logic        a_lvld_q, a_sel_q, a_hvld_q;
  logic        b_lvld_q, b_sel_q, b_hvld_q;
  logic [IdxW-1:0] ra_q, rb_q;

  // writes landing on the same edge as the read are missed by it
  rf_wr_t          byp_q;
  logic [IdxW-1:0] byp_cp_addr_q, byp_rd_addr_q;

  always_comb begin
    lo_vld_d = lo_vld_q;
    lo_sel_d = lo_sel_q;
    hi_vld_d = hi_vld_q;
    if (wr_i.cp_en) begin
      lo_vld_d[cp_addr_i] = 1'b1;
      lo_sel_d[cp_addr_i] = 1'b0;
    end
    if (wr_i.lo_en) begin
      lo_vld_d[rd_addr_i] = 1'b1;
      lo_sel_d[rd_addr_i] = 1'b1;
    end
    if (wr_i.hi_en) begin
      hi_vld_d[rd_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_vld_q <= '0;
      lo_sel_q <= '0;
      hi_vld_q <= '0;
      byp_q    <= '0;
      a_lvld_q <= 1'b0;
      a_sel_q  <= 1'b0;
      a_hvld_q <= 1'b0;
      b_lvld_q <= 1'b0;
      b_sel_q  <= 1'b0;
      b_hvld_q <= 1'b0;
    end else begin
      lo_vld_q <= lo_vld_d;
      lo_sel_q <= lo_sel_d;
      hi_vld_q <= hi_vld_d;
      if (rd_en_i) begin
        byp_q    <= wr_i;
        a_lvld_q <= lo_vld_q[ra_i];
        a_sel_q  <= lo_sel_q[ra_i];
        a_hvld_q <= hi_vld_q[ra_i];
        b_lvld_q <= lo_vld_q[rb_i];
        b_sel_q  <= lo_sel_q[rb_i];
        b_hvld_q <= hi_vld_q[rb_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cp_en) begin
      mem_cp[cp_addr_i] <= wr_i.cp_data;
    end
    if (wr_i.lo_en) begin
      mem_res[rd_addr_i] <= wr_i.lo_data;
    end
    if (wr_i.hi_en) begin
      mem_hi[rd_addr_i] <= wr_i.hi_data;
    end
    if (rd_en_i) begin
      cp_a_q        <= mem_cp[ra_i];
      cp_b_q        <= mem_cp[rb_i];
      res_a_q       <= mem_res[ra_i];
      res_b_q       <= mem_res[rb_i];
      hi_a_q        <= mem_hi[ra_i];
      hi_b_q        <= mem_hi[rb_i];
      ra_q          <= ra_i;
      rb_q          <= rb_i;
      byp_cp_addr_q <= cp_addr_i;
      byp_rd_addr_q <= rd_addr_i;
    end
  end

  always_comb begin
    a_lo_o = a_lvld_q ? (a_sel_q ? res_a_q : cp_a_q) : 32'd0;
    b_lo_o = b_lvld_q ? (b_sel_q ? res_b_q : cp_b_q) : 32'd0;
    a_hi_o = a_hvld_q ? hi_a_q : 32'd0;
    b_hi_o = b_hvld_q ? hi_b_q : 32'd0;
    // copy first, result write on top of it
    if (byp_q.cp_en && byp_cp_addr_q == ra_q) a_lo_o = byp_q.cp_data;
    if (byp_q.cp_en && byp_cp_addr_q == rb_q) b_lo_o = byp_q.cp_data;
    if (byp_q.lo_en && byp_rd_addr_q == ra_q) a_lo_o = byp_q.lo_data;
    if (byp_q.lo_en && byp_rd_addr_q == rb_q) b_lo_o = byp_q.lo_data;
    if (byp_q.hi_en && byp_rd_addr_q == ra_q) a_hi_o = byp_q.hi_data;
    if (byp_q.hi_en && byp_rd_addr_q == rb_q) b_hi_o = byp_q.hi_data;
  end

`ifndef SYNTHESIS
  a_sel_needs_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lo_sel_q & ~lo_vld_q) == '0)
    else $error("low bank select set on an entry never written");

  a_res_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.lo_en |=> lo_sel_q[$past(rd_addr_i)] && lo_vld_q[$past(rd_addr_i)])
    else $error("result write did not take the low bank entry");

  a_hi_with_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.hi_en |-> wr_i.lo_en)
    else $error("high bank written without the low half");
`endif

endmodule

`default_nettype wire

[rtl/shlsu_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module shlsu_alu (
  input  wire shlsu_pkg::in_t  item_i,
  input  wire logic            t_i,
  input  wire logic            same_ab_i,
  input  wire logic [31:0]     a_lo_i,
  input  wire logic [31:0]     a_hi_i,
  input  wire logic [31:0]     b_lo_i,
  input  wire logic [31:0]     b_hi_i,
  output shlsu_pkg::out_t      res_o,
  output shlsu_pkg::rf_wr_t    wr_o
);
  import shlsu_pkg::*;

  logic [31:0] imm32, a32, bl, b32, r32, sra32;
  logic [63:0] imm64, a64, b64, r64, val, sra64;
  logic [4:0]  sh5, neg5;
  logic [5:0]  sh6;
  logic        pair, wr, t, defined;

  always_comb begin
    imm32   = item_i.imm_value;
    imm64   = {{32{imm32[31]}}, imm32};
    // the immediate copy lands in the low bank before operands are read
    a32     = (item_i.copy_imm && same_ab_i) ? imm32 : a_lo_i;
    bl      = item_i.copy_imm ? imm32 : b_lo_i;
    b32     = item_i.use_imm ? imm32 : bl;
    a64     = {a_hi_i, a32};
    b64     = item_i.use_imm ? imm64 : {b_hi_i, bl};
    sh5     = b32[4:0];
    sh6     = b64[5:0];
    neg5    = 5'd0 - sh5;
    // arithmetic shifts kept apart so a mixed-sign select cannot turn them logical
    sra32   = $signed(a32) >>> sh5;
    sra64   = $signed(a64) >>> sh6;
    defined = item_i.func <= FN_LDSH16;
    r32     = '0;
    r64     = '0;
    pair    = 1'b0;
    wr      = 1'b1;
    t       = t_i;

    unique case (item_i.func) inside
      FN_AND, FN_OR, FN_XOR: begin
        if (item_i.wide) begin
          pair = 1'b1;
          r64  = (item_i.func == FN_AND) ? (a64 & b64) :
                 (item_i.func == FN_OR)  ? (a64 | b64) : (a64 ^ b64);
        end else begin
          r32  = (item_i.func == FN_AND) ? (a32 & b32) :
                 (item_i.func == FN_OR)  ? (a32 | b32) : (a32 ^ b32);
        end
      end
      FN_NOT: r32 = ~a32;
      FN_TST: begin
        wr = 1'b0;
        t  = item_i.wide ? ((a64 & b64) == '0) : ((a32 & b32) == '0);
      end
      FN_ROTL: begin
        r32 = {a32[30:0], a32[31]};
        t   = a32[31];
      end
      FN_ROTR: begin
        r32 = {a32[0], a32[31:1]};
        t   = a32[0];
      end
      FN_ROTCL: begin
        r32 = {a32[30:0], t_i};
        t   = a32[31];
      end
      FN_ROTCR: begin
        r32 = {t_i, a32[31:1]};
        t   = a32[0];
      end
      FN_SHAL, FN_SHLL: begin
        r32 = {a32[30:0], 1'b0};
        t   = a32[31];
      end
      FN_SHAR: begin
        r32 = {a32[31], a32[31:1]};
        t   = a32[0];
      end
      FN_SHLR: begin
        r32 = {1'b0, a32[31:1]};
        t   = a32[0];
      end
      FN_SHLL2:  r32 = a32 << 2;
      FN_SHLR2:  r32 = a32 >> 2;
      FN_SHLL8:  r32 = a32 << 8;
      FN_SHLR8:  r32 = a32 >> 8;
      FN_SHLL16: r32 = a32 << 16;
      FN_SHLR16: r32 = a32 >> 16;
      FN_SHAD, FN_SHLD: begin
        // negative amount shifts right by 32 - (s mod 32); s mod 32 == 0 fills
        if (!b32[31]) begin
          r32 = a32 << sh5;
        end else if (item_i.func == FN_SHAD) begin
          r32 = $signed(a32) >>> ((sh5 == 5'd0) ? 5'd31 : neg5);
        end else begin
          r32 = (sh5 == 5'd0) ? 32'd0 : (a32 >> neg5);
        end
      end
      FN_SHLLV, FN_SHLRV, FN_SHARV: begin
        if (item_i.wide) begin
          pair = 1'b1;
          r64  = (item_i.func == FN_SHLLV) ? (a64 << sh6) :
                 (item_i.func == FN_SHLRV) ? (a64 >> sh6) : sra64;
        end else begin
          r32  = (item_i.func == FN_SHLLV) ? (a32 << sh5) :
                 (item_i.func == FN_SHLRV) ? (a32 >> sh5) : sra32;
        end
      end
      FN_LDSH16: begin
        pair = 1'b1;
        r64  = {a64[47:0], 16'h0000} + imm64;
      end
      default: begin
        wr = 1'b0;
      end
    endcase

    if (!wr) begin
      val = '0;
    end else if (pair) begin
      val = r64;
    end else begin
      val = {32'd0, r32};
    end

    res_o.result_value = defined ? val : 64'd0;
    res_o.t_out        = defined ? t : t_i;
    res_o.wrote_reg    = defined && wr;

    wr_o.cp_en   = defined && item_i.copy_imm;
    wr_o.lo_en   = defined && wr;
    wr_o.hi_en   = defined && wr && pair;
    wr_o.cp_data = imm32;
    wr_o.lo_data = val[31:0];
    wr_o.hi_data = val[63:32];
  end

endmodule

`default_nettype wire

[rtl/sh_logic_shift_unit_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Logic / test / rotate / shift execute unit with its own register file
// (low and high 32-bit banks) and T flag.
// Input channel in_valid_i/in_ready_o carries one instruction word; output
// channel out_valid_o/out_ready_i carries one result word per instruction,
// in order.
// Path: an accepted word sits in the execute register, then in the output
// register, whose contents drive the output channel.
// Throughput: one word per cycle unless the receiver stalls. Register
// operands are read from the bank memories at acceptance; the write of the
// instruction ahead, landing on the same edge, is forwarded into the operands.
// Reset clears both banks (per-entry valid bits) and the T flag at once; the
// unit takes a word as soon as reset is released, with no clearing pass.
// Receiver stall: the result stays in the output register; one more word is
// taken into the execute register, then in_ready_o drops until the output
// drains. Register file and T flag update only when a word moves from
// execute to the output register.
module sh_logic_shift_unit_top #(
  parameter int NUM_REGS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire shlsu_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output shlsu_pkg::out_t      out_data_o
);
  import shlsu_pkg::*;

  localparam int IdxW = $clog2(NUM_REGS);
  localparam logic [7:0] NumRegs8 = 8'(NUM_REGS);

  // register field is 4 bits, below twice NUM_REGS for NUM_REGS of 8 or more: one compare and subtract
  function automatic logic [IdxW-1:0] reg_idx(input logic [3:0] r);
    logic [7:0] v;
    v = {4'd0, r};
    if (v >= NumRegs8) v = v - NumRegs8;
    return v[IdxW-1:0];
  endfunction

  logic            s1_vld_q, out_vld_q, t_q;
  in_t             s1_item_q;
  logic [IdxW-1:0] ra_q, rb_q, rd_q;
  out_t            out_q;
  logic            s1_adv, s1_fire, in_fire;
  logic [31:0]     a_lo, a_hi, b_lo, b_hi;
  out_t            alu_res;
  rf_wr_t          alu_wr, rf_wr;

  assign s1_adv     = !out_vld_q || out_ready_i;
  assign s1_fire    = s1_vld_q && s1_adv;
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    rf_wr = alu_wr;
    if (!s1_fire) begin
      rf_wr.cp_en = 1'b0;
      rf_wr.lo_en = 1'b0;
      rf_wr.hi_en = 1'b0;
    end
  end

  shlsu_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .ra_i      (reg_idx(in_data_i.src_a_reg)),
    .rb_i      (reg_idx(in_data_i.src_b_reg)),
    .wr_i      (rf_wr),
    .cp_addr_i (rb_q),
    .rd_addr_i (rd_q),
    .a_lo_o    (a_lo),
    .a_hi_o    (a_hi),
    .b_lo_o    (b_lo),
    .b_hi_o    (b_hi)
  );

  shlsu_alu u_alu (
    .item_i    (s1_item_q),
    .t_i       (t_q),
    .same_ab_i (ra_q == rb_q),
    .a_lo_i    (a_lo),
    .a_hi_i    (a_hi),
    .b_lo_i    (b_lo),
    .b_hi_i    (b_hi),
    .res_o     (alu_res),
    .wr_o      (alu_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      t_q       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_q <= 1'b1;
        t_q       <= alu_res.t_out;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
      ra_q      <= reg_idx(in_data_i.src_a_reg);
      rb_q      <= reg_idx(in_data_i.src_b_reg);
      rd_q      <= reg_idx(in_data_i.dest_reg);
    end
    if (s1_fire) begin
      out_q <= alu_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_wr_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rf_wr.cp_en || rf_wr.lo_en || rf_wr.hi_en) |-> s1_fire)
    else $error("register file written without an executing word");

  a_t_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(t_q))
    else $error("T flag changed with no word executed");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while execute stage is blocked");
`endif

endmodule

`default_nettype wire

[verif/sh_logic_shift_unit_top_test.sv]
`timescale 1ns / 1ps

module sh_logic_shift_unit_top_test;
  import shlsu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 1050;
  localparam int CALM_FROM = 900;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [4:0] FN_RESERVED = 5'd31;

  class shlsu_tracker;
    logic [31:0] lo_bank [16];
    logic [31:0] hi_bank [16];
    logic        t_bit;
    out_t        pending_results[$];
    int          taken;
    int          checked;
    int          undef_seen;
    int          pair_seen;
    int          errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        lo_bank[i] = '0;
        hi_bank[i] = '0;
      end
      t_bit = 1'b0;
    endfunction

    // executes one accepted word on the shadow register file
    function void take_instr(in_t w);
      logic [31:0] a, b, imm32, r32;
      logic [63:0] a64, b64, imm64, r64;
      logic        pair, wr, t;
      int unsigned n;
      func_e       f;
      out_t        e;
      taken++;
      if (w.func > FN_LDSH16) begin
        undef_seen++;
        e.result_value = '0;
        e.t_out = t_bit;
        e.wrote_reg = 1'b0;
        pending_results.push_back(e);
        return;
      end
      f = func_e'(w.func);
      imm32 = w.imm_value;
      imm64 = {{32{imm32[31]}}, imm32};
      if (w.copy_imm) lo_bank[w.src_b_reg] = imm32;
      a = lo_bank[w.src_a_reg];
      b = w.use_imm ? imm32 : lo_bank[w.src_b_reg];
      a64 = {hi_bank[w.src_a_reg], lo_bank[w.src_a_reg]};
      b64 = w.use_imm ? imm64 : {hi_bank[w.src_b_reg], lo_bank[w.src_b_reg]};
      r32 = '0;
      r64 = '0;
      pair = 1'b0;
      wr = 1'b1;
      t = t_bit;
      case (f)
        FN_AND, FN_OR, FN_XOR: begin
          if (w.wide) begin
            pair = 1'b1;
            if (f == FN_AND) r64 = a64 & b64;
            else if (f == FN_OR) r64 = a64 | b64;
            else r64 = a64 ^ b64;
          end else begin
            if (f == FN_AND) r32 = a & b;
            else if (f == FN_OR) r32 = a | b;
            else r32 = a ^ b;
          end
        end
        FN_NOT: r32 = ~a;
        FN_TST: begin
          wr = 1'b0;
          t = w.wide ? ((a64 & b64) == '0) : ((a & b) == '0);
        end
        FN_ROTL: begin
          r32 = {a[30:0], a[31]};
          t = a[31];
        end
        FN_ROTR: begin
          r32 = {a[0], a[31:1]};
          t = a[0];
        end
        FN_ROTCL: begin
          r32 = {a[30:0], t_bit};
          t = a[31];
        end
        FN_ROTCR: begin
          r32 = {t_bit, a[31:1]};
          t = a[0];
        end
        FN_SHAL, FN_SHLL: begin
          r32 = {a[30:0], 1'b0};
          t = a[31];
        end
        FN_SHAR: begin
          r32 = {a[31], a[31:1]};
          t = a[0];
        end
        FN_SHLR: begin
          r32 = {1'b0, a[31:1]};
          t = a[0];
        end
        FN_SHLL2:  r32 = a << 2;
        FN_SHLR2:  r32 = a >> 2;
        FN_SHLL8:  r32 = a << 8;
        FN_SHLR8:  r32 = a >> 8;
        FN_SHLL16: r32 = a << 16;
        FN_SHLR16: r32 = a >> 16;
        FN_SHAD, FN_SHLD: begin
          n = 32'(b[4:0]);
          // negative amount shifts right by 32 - n; n of zero means all the way
          if (!b[31]) r32 = a << n;
          else if (f == FN_SHAD) r32 = $signed(a) >>> ((n != 0) ? 32 - n : 31);
          else if (n != 0) r32 = a >> (32 - n);
          else r32 = '0;
        end
        FN_SHLLV, FN_SHLRV, FN_SHARV: begin
          if (w.wide) begin
            pair = 1'b1;
            n = 32'(b64[5:0]);
            if (f == FN_SHLLV) r64 = a64 << n;
            else if (f == FN_SHLRV) r64 = a64 >> n;
            else r64 = $signed(a64) >>> n;
          end else begin
            n = 32'(b[4:0]);
            if (f == FN_SHLLV) r32 = a << n;
            else if (f == FN_SHLRV) r32 = a >> n;
            else r32 = $signed(a) >>> n;
          end
        end
        FN_LDSH16: begin
          pair = 1'b1;
          r64 = (a64 << 16) + imm64;
        end
        default: ;
      endcase
      if (!pair) r64 = {32'd0, r32};
      if (wr) begin
        lo_bank[w.dest_reg] = r64[31:0];
        if (pair) hi_bank[w.dest_reg] = r64[63:32];
      end else begin
        r64 = '0;
      end
      t_bit = t;
      if (pair) pair_seen++;
      e.result_value = r64;
      e.t_out = t;
      e.wrote_reg = wr;
      pending_results.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch at result %0d, %s: got %h want %h", checked, what, got, want);
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        report("word with nothing pending", got.result_value, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value)
        report("result_value", got.result_value, want.result_value);
      if (got.t_out !== want.t_out)
        report("t_out", 64'(got.t_out), 64'(want.t_out));
      if (got.wrote_reg !== want.wrote_reg)
        report("wrote_reg", 64'(got.wrote_reg), 64'(want.wrote_reg));
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic calm;
  int   cycles;

  shlsu_tracker tracker;

  sh_logic_shift_unit_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // both channels sampled on the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) tracker.take_instr(in_data);
      if (out_valid && out_ready) tracker.check_result(out_data);
    end
  end

  function automatic in_t instr(logic [4:0] f, logic wide, logic use_imm, logic copy_imm,
                                logic [3:0] ra, logic [3:0] rb, logic [3:0] rd,
                                logic [31:0] imm);
    in_t w;
    w.func = f;
    w.wide = wide;
    w.use_imm = use_imm;
    w.copy_imm = copy_imm;
    w.src_a_reg = ra;
    w.src_b_reg = rb;
    w.dest_reg = rd;
    w.imm_value = imm;
    return w;
  endfunction

  function automatic in_t random_word();
    in_t w;
    if ($urandom_range(0, 39) == 0)
      w.func = 5'($urandom_range(int'(FN_LDSH16) + 1, int'(FN_RESERVED)));
    else
      w.func = 5'($urandom_range(0, int'(FN_LDSH16)));
    w.wide = 1'($urandom_range(0, 1));
    w.use_imm = 1'($urandom_range(0, 1));
    w.copy_imm = ($urandom_range(0, 2) == 0);
    // crowd onto a few registers half the time to hit back-to-back dependencies
    w.src_a_reg = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    w.src_b_reg = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    w.dest_reg = $urandom_range(0, 1) ? w.src_a_reg : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: w.imm_value = $urandom;
      1: w.imm_value = $urandom_range(0, 80) - 40;
      2: begin
        case ($urandom_range(0, 3))
          0: w.imm_value = 32'h8000_0000;
          1: w.imm_value = 32'h7FFF_FFFF;
          2: w.imm_value = 32'hFFFF_FFFF;
          default: w.imm_value = 32'd0;
        endcase
      end
      default: w.imm_value = $urandom_range(0, 70);
    endcase
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task send_word(in_t w);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off to back up the input side
  initial begin
    int  hold;
    bit  held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        hold = 1;
      end else if (!held && tracker.taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        hold = HOLD_CYCLES;
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 13);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 20);
      end
      repeat (hold) @(negedge clk_i);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    tracker = new();
    calm = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // r1 := all ones by copy; wide OR loads r2 with the sign-extended immediate
    send_word(instr(FN_AND, 1'b0, 1'b0, 1'b1, 4'd0, 4'd1, 4'd0, 32'hFFFF_FFFF));
    send_word(instr(FN_OR, 1'b1, 1'b1, 1'b0, 4'd2, 4'd0, 4'd2, 32'h8000_0000));
    send_word(instr(FN_NOT, 1'b0, 1'b0, 1'b0, 4'd1, 4'd0, 4'd3, 32'd0));
    send_word(instr(FN_TST, 1'b0, 1'b1, 1'b0, 4'd1, 4'd0, 4'd0, 32'd0));
    send_word(instr(FN_XOR, 1'b1, 1'b0, 1'b0, 4'd1, 4'd2, 4'd4, 32'd0));
    for (int f = FN_ROTL; f <= FN_SHLR16; f++)
      send_word(instr(5'(f), 1'b1, 1'b0, 1'b0, (f % 2 != 0) ? 4'd1 : 4'd2, 4'd0, 4'd8,
                      32'd0));
    // negative amount with zero low bits: full fill / clear
    send_word(instr(FN_SHAD, 1'b0, 1'b0, 1'b1, 4'd2, 4'd9, 4'd10, 32'hFFFF_FFE0));
    send_word(instr(FN_SHLD, 1'b0, 1'b0, 1'b1, 4'd1, 4'd9, 4'd11, 32'hFFFF_FFE0));
    send_word(instr(FN_SHAD, 1'b0, 1'b1, 1'b0, 4'd2, 4'd0, 4'd12, 32'hFFFF_FFFF));
    send_word(instr(FN_SHLD, 1'b0, 1'b1, 1'b0, 4'd1, 4'd0, 4'd13, 32'd31));
    send_word(instr(FN_SHLLV, 1'b1, 1'b1, 1'b0, 4'd2, 4'd0, 4'd14, 32'd63));
    send_word(instr(FN_SHLRV, 1'b1, 1'b1, 1'b0, 4'd2, 4'd0, 4'd15, 32'd64));
    send_word(instr(FN_SHARV, 1'b0, 1'b1, 1'b0, 4'd2, 4'd0, 4'd6, 32'd33));
    send_word(instr(FN_LDSH16, 1'b0, 1'b0, 1'b0, 4'd2, 4'd0, 4'd7, 32'hFFFF_FFFF));
    // undefined op must not perform the copy
    send_word(instr(FN_RESERVED, 1'b1, 1'b1, 1'b1, 4'd3, 4'd3, 4'd3, 32'h7FFF_FFFF));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      send_word(random_word());
    end
    in_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d instruction words run, %0d pair forms, %0d undefined ops, %0d results checked",
             tracker.taken, tracker.pair_seen, tracker.undef_seen, tracker.checked);
    $display("random stalls on both sides, one %0d-cycle output hold-off, idle-free tail",
             HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/shlsu_pkg.sv
rtl/shlsu_regfile.sv
rtl/shlsu_alu.sv
rtl/sh_logic_shift_unit_top.sv
verif/sh_logic_shift_unit_top_test.sv
